### sv/assert_macros.svh
// Assertion macros shared by the tile map despeckle RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define TMD_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check a consequence in the same cycle as its cause.
`define TMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define TMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tmd_pkg.sv
// Package of widths, defaults and register indexes for the tile map despeckle unit.
`default_nettype none

package tmd_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int TERRAIN_BITS_DEF = 16;

    localparam int TERRAIN_W   = 16;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 16;
    localparam int VALUE_W     = 16;
    localparam int MAP_WIDTH_W = 11;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH  = 2'd0,
        REG_MAP_HEIGHT = 2'd1
    } cfg_reg_t;

endpackage

`default_nettype wire

### sv/tile_map_despeckle_unit.sv
// Top level of the streaming four-neighbour tile map despeckle unit.
// Path: a completing beat is held in the item stage, its result in the output register.
// Throughput: one cell per cycle while the output is not stalled and each cell yields at most
// one result; last-row cells yield up to three, sent one by one through the output register.
// Reset: position (0,0), width and height 1; the two line banks are not cleared, since every
// entry whose value is used was written earlier in the same map.
`default_nettype none
`include "assert_macros.svh"

module tile_map_despeckle_unit
    import tmd_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int TERRAIN_BITS = TERRAIN_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cell_valid,
    output logic                        cell_stall,
    input  wire logic [TERRAIN_W-1:0]   terrain,

    output logic                        res_valid,
    input  wire logic                   res_stall,
    output logic [COL_W-1:0]            col,
    output logic [ROW_W-1:0]            row,
    output logic [VALUE_W-1:0]          value,
    output logic                        replaced,
    output logic                        last,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int TB = TERRAIN_BITS;

    function automatic logic [TB-1:0] despeckle(
        input logic [TB-1:0] c,
        input logic [TB-1:0] nl,
        input logic [TB-1:0] nr,
        input logic [TB-1:0] nu,
        input logic [TB-1:0] nd
    );
        logic [TB-1:0] nb [4];
        logic [TB-1:0] cand;
        logic          rej;
        nb[0] = nl;
        nb[1] = nr;
        nb[2] = nu;
        nb[3] = nd;
        cand  = '0;
        rej   = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            if (!rej)
            begin
                if (nb[j] == c || (cand != '0 && cand != nb[j]))
                begin
                    rej = 1'b1;
                end
                else if (cand == '0)
                begin
                    cand = nb[j];
                end
            end
        end
        return rej ? '0 : cand;
    endfunction

    // configuration and position
    logic [WW-1:0]     width_reg, width_next;
    logic [ROW_W-1:0]  height_reg, height_next;
    logic [AW-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic              take;
    logic [WW-1:0]     x_ext;
    logic [WW-1:0]     x_inc;
    logic              rgt_ok;
    logic              x_last;
    logic              last_row;
    logic [AW-1:0]     addr_b;
    logic [TB-1:0]     cur;
    logic [MAP_WIDTH_W-1:0] cfg_map_w;

    // line banks, row r lives in bank r mod 2
    logic [TB-1:0]     bank0_mem [MAX_WIDTH];
    logic [TB-1:0]     bank1_mem [MAX_WIDTH];
    logic [TB-1:0]     b0a_reg, b0b_reg, b1a_reg, b1b_reg;

    // item stage
    logic [AW-1:0]     s1_x_reg;
    logic [ROW_W-1:0]  s1_r_reg;
    logic [TB-1:0]     s1_cur_reg;
    logic              s1_par_reg;
    logic              s1_above_reg;
    logic              s1_up2_reg;
    logic              s1_xge1_reg;
    logic              s1_xge2_reg;
    logic              s1_rgt_ok_reg;
    logic [TB-1:0]     prev_ctr_reg;
    logic [TB-1:0]     prev_cur_reg;
    logic [TB-1:0]     prev2_cur_reg;
    logic [2:0]        pend_reg, pend_next;
    logic [2:0]        pend_after;
    logic [2:0]        pend_low;
    logic [2:0]        pend_new;

    // output register
    logic              res_valid_reg;
    logic [COL_W-1:0]  res_col_reg, res_col_next;
    logic [ROW_W-1:0]  res_row_reg, res_row_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic              res_replaced_reg, res_replaced_next;
    logic              res_last_reg, res_last_next;
    logic              out_free;
    logic              out_load;

    logic [TB-1:0]     ctr;
    logic [TB-1:0]     rgt;
    logic [TB-1:0]     up;
    logic [TB-1:0]     cand0, cand1, cand2;

    assign cur       = TB'(terrain);
    assign x_ext     = WW'(col_reg);
    assign x_inc     = x_ext + WW'(1);
    assign rgt_ok    = x_inc < width_reg;
    assign x_last    = x_inc == width_reg;
    assign last_row  = row_reg == (height_reg - ROW_W'(1));
    assign addr_b    = rgt_ok ? x_inc[AW-1:0] : col_reg;
    assign cfg_map_w = cfg_data[MAP_WIDTH_W-1:0];

    assign pend_new  = {x_last && last_row, (col_reg != '0) && last_row, row_reg != '0};

    // configuration and position counters
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:
                begin
                    if (cfg_map_w == '0)
                    begin
                        width_next = WW'(1);
                    end
                    else if (int'(cfg_map_w) > MAX_WIDTH)
                    begin
                        width_next = WW'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_next = WW'(cfg_map_w);
                    end
                    col_next = '0;
                    row_next = '0;
                end
                REG_MAP_HEIGHT:
                begin
                    height_next = (cfg_data == '0) ? ROW_W'(1) : ROW_W'(cfg_data);
                    col_next    = '0;
                    row_next    = '0;
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
        else if (take)
        begin
            if (x_last)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = x_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(1);
            height_reg <= ROW_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // line banks: read before write at the same address
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (!row_reg[0])
            begin
                bank0_mem[col_reg] <= cur;
            end
            b0a_reg <= bank0_mem[col_reg];
            b0b_reg <= bank0_mem[addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (row_reg[0])
            begin
                bank1_mem[col_reg] <= cur;
            end
            b1a_reg <= bank1_mem[col_reg];
            b1b_reg <= bank1_mem[addr_b];
        end
    end

    // item stage and neighbor history
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_x_reg      <= col_reg;
            s1_r_reg      <= row_reg;
            s1_cur_reg    <= cur;
            s1_par_reg    <= row_reg[0];
            s1_above_reg  <= row_reg != '0;
            s1_up2_reg    <= row_reg > ROW_W'(1);
            s1_xge1_reg   <= col_reg != '0;
            s1_xge2_reg   <= x_ext > WW'(1);
            s1_rgt_ok_reg <= rgt_ok;
            prev_ctr_reg  <= ctr;
            prev_cur_reg  <= s1_cur_reg;
            prev2_cur_reg <= prev_cur_reg;
        end
    end

    assign ctr = s1_par_reg ? b0a_reg : b1a_reg;
    assign rgt = s1_par_reg ? b0b_reg : b1b_reg;
    assign up  = s1_par_reg ? b1a_reg : b0a_reg;

    assign cand0 = despeckle(ctr,
                             s1_xge1_reg   ? prev_ctr_reg : '0,
                             s1_rgt_ok_reg ? rgt          : '0,
                             s1_up2_reg    ? up           : '0,
                             s1_cur_reg);
    assign cand1 = despeckle(prev_cur_reg,
                             s1_xge2_reg  ? prev2_cur_reg : '0,
                             s1_cur_reg,
                             s1_above_reg ? prev_ctr_reg  : '0,
                             '0);
    assign cand2 = despeckle(s1_cur_reg,
                             s1_xge1_reg  ? prev_cur_reg : '0,
                             '0,
                             s1_above_reg ? ctr          : '0,
                             '0);

    // result order: cell above, left cell of last row, current cell of last row
    always_comb
    begin
        if (pend_reg[0])
        begin
            res_col_next      = COL_W'(s1_x_reg);
            res_row_next      = s1_r_reg - ROW_W'(1);
            res_value_next    = VALUE_W'((cand0 != '0) ? cand0 : ctr);
            res_replaced_next = cand0 != '0;
            res_last_next     = 1'b0;
        end
        else if (pend_reg[1])
        begin
            res_col_next      = COL_W'(s1_x_reg - AW'(1));
            res_row_next      = s1_r_reg;
            res_value_next    = VALUE_W'((cand1 != '0) ? cand1 : prev_cur_reg);
            res_replaced_next = cand1 != '0;
            res_last_next     = 1'b0;
        end
        else
        begin
            res_col_next      = COL_W'(s1_x_reg);
            res_row_next      = s1_r_reg;
            res_value_next    = VALUE_W'((cand2 != '0) ? cand2 : s1_cur_reg);
            res_replaced_next = cand2 != '0;
            res_last_next     = 1'b1;
        end
    end

    assign out_free   = !res_valid_reg || !res_stall;
    assign out_load   = out_free && (pend_reg != '0);
    assign pend_low   = pend_reg & (~pend_reg + 3'd1);
    assign pend_after = out_load ? (pend_reg & ~pend_low) : pend_reg;
    assign take       = cell_valid && (pend_after == '0);
    assign cell_stall = pend_after != '0;
    assign pend_next  = take ? pend_new : pend_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_col_reg      <= res_col_next;
            res_row_reg      <= res_row_next;
            res_value_reg    <= res_value_next;
            res_replaced_reg <= res_replaced_next;
            res_last_reg     <= res_last_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign col       = res_col_reg;
    assign row       = res_row_reg;
    assign value     = res_value_reg;
    assign replaced  = res_replaced_reg;
    assign last      = res_last_reg;

    `TMD_ASSERT_ALWAYS(a_pos_in_map, clk, rst_n, (x_ext < width_reg) && (row_reg < height_reg), "position outside the map")
    `TMD_ASSERT_IMP(a_beat_from_pending, clk, rst_n, $rose(res_valid_reg), $past(pend_reg != 3'b000), "result beat without pending result")
    `TMD_ASSERT_NEXT(a_pending_hold, clk, rst_n, res_valid_reg && res_stall && (pend_reg != 3'b000), $stable(pend_reg), "pending results changed under stall")

endmodule

`default_nettype wire
